>>> rtl/core/ookpw_pkg.sv
`timescale 1ns / 1ps

package ookpw_pkg;

	// configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// code length and repeat count register widths
	localparam int unsigned LEN_W = 7;
	localparam int unsigned REP_W = 4;

	// register reset values
	localparam logic [LEN_W-1:0] CODE_LENGTH_RESET  = 7'd1;
	localparam logic [REP_W-1:0] REPEAT_TOTAL_RESET = 4'd10;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH    = 3'd0,
		REG_ZERO_LOW     = 3'd1,
		REG_ONE_HIGH     = 3'd2,
		REG_ONE_LOW      = 3'd3,
		REG_GAP          = 3'd4,
		REG_CODE_PATTERN = 3'd5,
		REG_CODE_LENGTH  = 3'd6,
		REG_REPEAT_TOTAL = 3'd7
	} cfg_reg_t;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_LOW  = 4'b0100,
		PH_GAP  = 4'b1000
	} phase_t;

endpackage

>>> rtl/core/ook_pulse_width_code_sender.sv
`timescale 1ns / 1ps

// On-off keyed pulse-width code sender.
// Input channel (in_valid/in_ready, start_req): one item per clock tick of pulse
// timing. start_req high on an idle tick starts a transmission; while busy it is
// ignored. That first tick already drives the high of code bit 0.
// Output channel (out_valid/out_ready): exactly one item per input item, carrying
// pin_level, busy_res and finished (finished marks the last tick of the last gap).
// Config port (cfg_we, cfg_index, cfg_data): single-cycle writes, no read-back;
// write only while no transmission is under way.
// Latency: an input item's result is registered and shows on the next cycle.
// Throughput: one item per cycle; the sequencer state and the result register
// both update in the cycle an item is taken, so the tick rate is set only by
// the single output register draining.
// Stall: when out_ready is low with a result held, in_ready drops and the
// sequencer freezes until the result is taken; nothing is lost or repeated.
// Reset (arst_n low): sequencer idle, output register empty, timing registers
// and pattern cleared, code length 1, repeat total 10.
module ook_pulse_width_code_sender #(
	parameter int unsigned MAX_CODE_BITS = 64,
	parameter int unsigned TIME_BITS     = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tick input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_req,
	// pin output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pin_level,
	output logic                                busy_res,
	output logic                                finished,
	// configuration
	input  logic                                cfg_we,
	input  logic [ookpw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ookpw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned BPW = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
	localparam logic [ookpw_pkg::LEN_W-1:0] MAX_LEN = ookpw_pkg::LEN_W'(MAX_CODE_BITS);

	// ticks left after the first tick of a phase
	function automatic logic [TIME_BITS-1:0] after_first(input logic [TIME_BITS-1:0] d);
		return (d == '0) ? '0 : d - TIME_BITS'(1);
	endfunction

	// configuration registers
	logic [TIME_BITS-1:0]              zero_high_q, zero_low_q, one_high_q, one_low_q, gap_q;
	logic [MAX_CODE_BITS-1:0]          pattern_q;
	logic [ookpw_pkg::LEN_W-1:0]       length_q;
	logic [ookpw_pkg::REP_W-1:0]       repeat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= '0;
			zero_low_q  <= '0;
			one_high_q  <= '0;
			one_low_q   <= '0;
			gap_q       <= '0;
			pattern_q   <= '0;
			length_q    <= ookpw_pkg::CODE_LENGTH_RESET;
			repeat_q    <= ookpw_pkg::REPEAT_TOTAL_RESET;
		end else if (cfg_we) begin
			unique case (ookpw_pkg::cfg_reg_t'(cfg_index))
				ookpw_pkg::REG_ZERO_HIGH:    zero_high_q <= cfg_data[TIME_BITS-1:0];
				ookpw_pkg::REG_ZERO_LOW:     zero_low_q  <= cfg_data[TIME_BITS-1:0];
				ookpw_pkg::REG_ONE_HIGH:     one_high_q  <= cfg_data[TIME_BITS-1:0];
				ookpw_pkg::REG_ONE_LOW:      one_low_q   <= cfg_data[TIME_BITS-1:0];
				ookpw_pkg::REG_GAP:          gap_q       <= cfg_data[TIME_BITS-1:0];
				ookpw_pkg::REG_CODE_PATTERN: pattern_q   <= cfg_data[MAX_CODE_BITS-1:0];
				ookpw_pkg::REG_CODE_LENGTH:  length_q    <= cfg_data[ookpw_pkg::LEN_W-1:0];
				ookpw_pkg::REG_REPEAT_TOTAL: repeat_q    <= cfg_data[ookpw_pkg::REP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state
	ookpw_pkg::phase_t             phase_q;
	logic [BPW-1:0]                bit_pos_q;
	logic [ookpw_pkg::REP_W-1:0]   reps_q;
	logic [TIME_BITS-1:0]          ticks_q;

	// output register
	logic out_valid_q, pin_q, busy_q, fin_q;

	logic accept;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// effective length and repeat count
	logic [ookpw_pkg::LEN_W-1:0] eff_len;
	logic [ookpw_pkg::REP_W:0]   eff_rep;
	always_comb begin
		if (length_q == '0) begin
			eff_len = ookpw_pkg::LEN_W'(1);
		end else if (length_q > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = length_q;
		end
		eff_rep = (repeat_q == '0) ? (ookpw_pkg::REP_W+1)'(1) : {1'b0, repeat_q};
	end

	// one tick of the sequencer
	ookpw_pkg::phase_t             ph_cur, ph_d;
	logic [BPW-1:0]                bp_cur, bp_d, bp_inc;
	logic [ookpw_pkg::REP_W-1:0]   reps_cur, reps_d;
	logic [TIME_BITS-1:0]          ticks_cur, ticks_d;
	logic                          pin_d, busy_d, fin_d;
	logic                          bit_cur, bit_next, bit0;
	logic                          last_bit, last_pass;

	always_comb begin
		bit0 = pattern_q[0];

		// start request on an idle tick enters the high of bit 0
		if (phase_q == ookpw_pkg::PH_IDLE && start_req) begin
			ph_cur    = ookpw_pkg::PH_HIGH;
			bp_cur    = '0;
			reps_cur  = '0;
			ticks_cur = after_first(bit0 ? one_high_q : zero_high_q);
		end else begin
			ph_cur    = phase_q;
			bp_cur    = bit_pos_q;
			reps_cur  = reps_q;
			ticks_cur = ticks_q;
		end

		bp_inc    = bp_cur + BPW'(1);
		bit_cur   = pattern_q[bp_cur];
		bit_next  = pattern_q[bp_inc];
		last_bit  = (ookpw_pkg::LEN_W'(bp_cur) + ookpw_pkg::LEN_W'(1)) >= eff_len;
		last_pass = ({1'b0, reps_cur} + (ookpw_pkg::REP_W+1)'(1)) >= eff_rep;

		ph_d    = ph_cur;
		bp_d    = bp_cur;
		reps_d  = reps_cur;
		ticks_d = ticks_cur;
		pin_d   = 1'b0;
		busy_d  = 1'b0;
		fin_d   = 1'b0;

		if (ph_cur != ookpw_pkg::PH_IDLE) begin
			busy_d = 1'b1;
			pin_d  = (ph_cur == ookpw_pkg::PH_HIGH);
			if (ticks_cur != '0) begin
				ticks_d = ticks_cur - TIME_BITS'(1);
			end else begin
				unique case (ph_cur)
					ookpw_pkg::PH_HIGH: begin
						ph_d    = ookpw_pkg::PH_LOW;
						ticks_d = after_first(bit_cur ? one_low_q : zero_low_q);
					end
					ookpw_pkg::PH_LOW: begin
						if (last_bit) begin
							ph_d    = ookpw_pkg::PH_GAP;
							ticks_d = after_first(gap_q);
						end else begin
							ph_d    = ookpw_pkg::PH_HIGH;
							bp_d    = bp_inc;
							ticks_d = after_first(bit_next ? one_high_q : zero_high_q);
						end
					end
					ookpw_pkg::PH_GAP: begin
						if (last_pass) begin
							fin_d   = 1'b1;
							ph_d    = ookpw_pkg::PH_IDLE;
							bp_d    = '0;
							reps_d  = '0;
							ticks_d = '0;
						end else begin
							ph_d    = ookpw_pkg::PH_HIGH;
							bp_d    = '0;
							reps_d  = reps_cur + ookpw_pkg::REP_W'(1);
							ticks_d = after_first(bit0 ? one_high_q : zero_high_q);
						end
					end
					default: begin
						ph_d = ookpw_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// state advances only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ookpw_pkg::PH_IDLE;
			bit_pos_q <= '0;
			reps_q    <= '0;
			ticks_q   <= '0;
		end else if (accept) begin
			phase_q   <= ph_d;
			bit_pos_q <= bp_d;
			reps_q    <= reps_d;
			ticks_q   <= ticks_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pin_q  <= pin_d;
			busy_q <= busy_d;
			fin_q  <= fin_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = pin_q;
	assign busy_res  = busy_q;
	assign finished  = fin_q;

`ifndef SYNTHESIS
	// the finishing tick is a busy tick with the pin low
	a_fin_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> (busy_res && !pin_level))
		else $error("finished item not busy or pin high");

	// an idle item never drives the pin
	a_idle_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_res) |-> !pin_level)
		else $error("pin high while idle");

	// idle state carries no leftover counts
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ookpw_pkg::PH_IDLE) |-> (ticks_q == '0 && bit_pos_q == '0 && reps_q == '0))
		else $error("idle with stale counters");

	// a finishing tick returns the sequencer to idle
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fin_d) |=> (phase_q == ookpw_pkg::PH_IDLE))
		else $error("sequencer not idle after finish");

	// the sequencer holds while no tick is taken
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(phase_q) && $stable(ticks_q)))
		else $error("sequencer moved without a tick");
`endif

endmodule
